// ----- rtl/core/fpp_pkg.sv -----
// ----------------------------------------------------------------------------
// fpp_pkg
// Types and constants shared by the flux peak picker modules.
// ----------------------------------------------------------------------------
package fpp_pkg;

  // Operation codes carried in the input word
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SHARE_LOUDEST = 2'd0;
  localparam logic [1:0] CFG_SHARE_LOCAL   = 2'd1;
  localparam logic [1:0] CFG_RISE_SHARE    = 2'd2;

  // Configuration reset values (Q0.16)
  localparam logic [15:0] SHARE_LOUDEST_RST = 16'd3932;
  localparam logic [15:0] SHARE_LOCAL_RST   = 16'd7864;
  localparam logic [15:0] RISE_SHARE_RST    = 16'd13107;

  typedef struct packed {
    logic        operation;
    logic        first_frame;
    logic [31:0] flux_value;
    logic [11:0] query_frame;
  } item_t;

  typedef struct packed {
    logic        is_peak;
    logic [11:0] rise_frame;
    logic        in_range;
    logic [12:0] frames_held;
    logic        store_full;
  } result_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [15:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL_SHARE,
    ST_MUL_RISE,
    ST_MUL_LOCAL,
    ST_PEAK_SCAN,
    ST_PEAK_LAST,
    ST_LOCAL_SCAN,
    ST_LOCAL_LAST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_VN,
    ST_COMPARE,
    ST_RISE_RD,
    ST_RISE_CMP,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/core/fpp_ram.sv -----
// ----------------------------------------------------------------------------
// fpp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/fpp_mul.sv -----
// ----------------------------------------------------------------------------
// fpp_mul
// Shared 32x16 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module fpp_mul import fpp_pkg::*; (
  input  logic        clk,
  input  mul_req_t    req,
  output logic [47:0] prod
);

  // hold the product until the next request
  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= 48'(req.a) * 48'(req.b);
    end
  end

endmodule

// ----- rtl/core/flux_peak_picker_unit.sv -----
// ----------------------------------------------------------------------------
// flux_peak_picker_unit
// Spectral-flux store with peak picking and rise search over a shared
// multiplier and a single-read flux RAM.
// ----------------------------------------------------------------------------
// Sequence: a load, or a query outside the held frames, goes from dispatch to
//   finish and the result register. An in-range query runs three multiplies,
//   scans of the clipped peak and local windows (7 and 21 frames at most),
//   three more multiplies, a compare and a rise walk back before finish.
// Throughput: one word in flight; the RAM read port and the multiplier set the
//   cost, one window frame or one rise step per read.
// Reset (rst, synchronous): store empty, maximum zero, registers at defaults.
module flux_peak_picker_unit import fpp_pkg::*; #(
  parameter int MAX_FRAMES  = 4096,
  parameter int PEAK_REACH  = 3,
  parameter int LOCAL_REACH = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // address, count and window-size widths
  localparam int AW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int XW = (CW > 12 ? CW : 12) + 1;
  localparam int NW = $clog2(2 * LOCAL_REACH + 2);
  localparam int SW = 32 + NW;
  localparam int RW = 49 + NW;

  state_t state, state_next;

  // configuration
  logic [15:0] share_loudest, share_local, rise_share;

  // persistent store state
  logic [CW-1:0] frame_count;
  logic [31:0]   loudest_flux;

  // latched word
  item_t cur_item;

  // query work registers
  logic [AW-1:0] qa;
  logic [31:0]   v;
  logic [47:0]   limit;
  logic [47:0]   p2;
  logic [CW-1:0] k, pk_lo, pk_last, lc_lo, lc_last;
  logic [NW-1:0] win_n;
  logic [SW-1:0] sum;
  logic [RW-1:0] rhs;
  logic          rd_vld;
  logic [AW-1:0] r;
  logic [31:0]   cur_flux;
  logic          peak_ok, in_rng, full;

  // memory and multiplier connections
  logic          mem_we;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [31:0]   rd_data;
  mul_req_t      mul_req;
  logic [47:0]   prod;

  // load-side decode
  logic [CW-1:0] cnt_eff;
  logic [31:0]   loud_eff;
  logic          load_full;
  logic          q_in_range;
  logic [CW-1:0] qx;
  logic [CW:0]   pk_hi_t, lc_hi_t, pk_hi, lc_hi;

  // Low edge of the local window, as used for the window count
  function automatic logic [CW-1:0] lc_lo_calc(input logic [CW-1:0] q);
    lc_lo_calc = (q > CW'(LOCAL_REACH)) ? q - CW'(LOCAL_REACH) : '0;
  endfunction

  fpp_ram #(
    .WIDTH (32),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cur_item.flux_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fpp_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign item_ready = (state == ST_IDLE);

  // Load decode: a first frame empties the store before it is written
  assign cnt_eff   = cur_item.first_frame ? '0 : frame_count;
  assign loud_eff  = cur_item.first_frame ? 32'd0 : loudest_flux;
  assign load_full = (cnt_eff >= CW'(MAX_FRAMES));
  assign mem_waddr = AW'(cnt_eff);

  // Query decode and window bounds, clipped at both ends of the held run
  assign q_in_range = XW'(cur_item.query_frame) < XW'(frame_count);
  assign qx         = CW'(cur_item.query_frame);
  assign pk_hi_t    = (CW + 1)'(qx) + (CW + 1)'(PEAK_REACH + 1);
  assign lc_hi_t    = (CW + 1)'(qx) + (CW + 1)'(LOCAL_REACH + 1);
  assign pk_hi      = (pk_hi_t > (CW + 1)'(frame_count)) ? (CW + 1)'(frame_count) : pk_hi_t;
  assign lc_hi      = (lc_hi_t > (CW + 1)'(frame_count)) ? (CW + 1)'(frame_count) : lc_hi_t;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (cur_item.operation == OP_QUERY && q_in_range) begin
          state_next = ST_MUL_SHARE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MUL_SHARE:  state_next = ST_MUL_RISE;
      ST_MUL_RISE:   state_next = ST_MUL_LOCAL;
      ST_MUL_LOCAL:  state_next = ST_PEAK_SCAN;
      ST_PEAK_SCAN: begin
        if (k == pk_last) state_next = ST_PEAK_LAST;
      end
      ST_PEAK_LAST:  state_next = ST_LOCAL_SCAN;
      ST_LOCAL_SCAN: begin
        if (k == lc_last) state_next = ST_LOCAL_LAST;
      end
      ST_LOCAL_LAST: state_next = ST_MUL_LO;
      ST_MUL_LO:     state_next = ST_MUL_HI;
      ST_MUL_HI:     state_next = ST_MUL_VN;
      ST_MUL_VN:     state_next = ST_COMPARE;
      ST_COMPARE:    state_next = ST_RISE_RD;
      ST_RISE_RD: begin
        state_next = (r == '0) ? ST_FINISH : ST_RISE_CMP;
      end
      ST_RISE_CMP: begin
        if (rd_data < cur_flux && {rd_data, 16'h0000} > limit) begin
          state_next = ST_RISE_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM port and multiplier operands
  always_comb begin
    mem_we  = 1'b0;
    rd_addr = '0;
    mul_req = '0;
    unique case (state)
      ST_DISPATCH: begin
        mem_we  = (cur_item.operation == OP_LOAD) && !load_full;
        rd_addr = qa;
      end
      ST_MUL_SHARE: begin
        // share of loudest times loudest
        mul_req = '{start: 1'b1, a: loudest_flux, b: share_loudest};
      end
      ST_MUL_RISE: begin
        // rise limit from the peak value
        mul_req = '{start: 1'b1, a: v, b: rise_share};
      end
      ST_MUL_LOCAL: begin
        mul_req = '{start: 1'b1, a: loudest_flux, b: share_local};
      end
      ST_PEAK_SCAN, ST_LOCAL_SCAN: begin
        rd_addr = AW'(k);
      end
      ST_MUL_LO: begin
        mul_req = '{start: 1'b1, a: p2[31:0], b: 16'(win_n)};
      end
      ST_MUL_HI: begin
        mul_req = '{start: 1'b1, a: 32'(p2[47:32]), b: 16'(win_n)};
      end
      ST_MUL_VN: begin
        mul_req = '{start: 1'b1, a: v, b: 16'(win_n)};
      end
      ST_RISE_RD: begin
        rd_addr = r - AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      share_loudest <= SHARE_LOUDEST_RST;
      share_local   <= SHARE_LOCAL_RST;
      rise_share    <= RISE_SHARE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SHARE_LOUDEST: share_loudest <= cfg_data;
        CFG_SHARE_LOCAL:   share_local   <= cfg_data;
        CFG_RISE_SHARE:    rise_share    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store control state: count and running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= '0;
      loudest_flux <= '0;
    end else if (state == ST_DISPATCH && cur_item.operation == OP_LOAD) begin
      if (!load_full) begin
        frame_count  <= cnt_eff + CW'(1);
        loudest_flux <= (cur_item.flux_value > loud_eff) ? cur_item.flux_value : loud_eff;
      end else begin
        frame_count  <= cnt_eff;
        loudest_flux <= loud_eff;
      end
    end
  end

  // RAM read data is valid the cycle after a scan read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_PEAK_SCAN) || (state == ST_LOCAL_SCAN);
    end
  end

  // Result register: parts the block from a stalled consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FINISH && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!result_valid || result_ready)) begin
      result.is_peak     <= peak_ok;
      result.rise_frame  <= 12'(r);
      result.in_range    <= in_rng;
      result.frames_held <= 13'(frame_count);
      result.store_full  <= full;
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur_item <= item;
        qa       <= AW'(XW'(item.query_frame));
      end
      ST_DISPATCH: begin
        // default answer for loads and out-of-range queries
        peak_ok <= 1'b0;
        r       <= '0;
        in_rng  <= (cur_item.operation == OP_QUERY) && q_in_range;
        full    <= (cur_item.operation == OP_LOAD) && load_full;
        pk_lo   <= (qx > CW'(PEAK_REACH)) ? qx - CW'(PEAK_REACH) : '0;
        lc_lo   <= (qx > CW'(LOCAL_REACH)) ? qx - CW'(LOCAL_REACH) : '0;
        pk_last <= CW'(pk_hi - (CW + 1)'(1));
        lc_last <= CW'(lc_hi - (CW + 1)'(1));
        win_n   <= NW'(lc_hi - (CW + 1)'(lc_lo_calc(qx)));
      end
      ST_MUL_SHARE: begin
        v <= rd_data;
      end
      ST_MUL_RISE: begin
        peak_ok <= (loudest_flux != 32'd0) && ({v, 16'h0000} >= prod);
      end
      ST_MUL_LOCAL: begin
        limit <= prod;
        k     <= pk_lo;
      end
      ST_PEAK_SCAN: begin
        if (rd_vld && rd_data > v) peak_ok <= 1'b0;
        if (k != pk_last) k <= k + CW'(1);
      end
      ST_PEAK_LAST: begin
        if (rd_data > v) peak_ok <= 1'b0;
        k   <= lc_lo;
        sum <= '0;
      end
      ST_LOCAL_SCAN: begin
        if (rd_vld) sum <= sum + SW'(rd_data);
        if (k != lc_last) k <= k + CW'(1);
      end
      ST_LOCAL_LAST: begin
        sum <= sum + SW'(rd_data);
        p2  <= prod;
      end
      ST_MUL_HI: begin
        // window sum scaled, plus low part of share times count
        rhs <= (RW'(sum) << 16) + RW'(prod);
      end
      ST_MUL_VN: begin
        rhs <= rhs + (RW'(prod) << 32);
      end
      ST_COMPARE: begin
        if (!((RW'(prod) << 16) > rhs)) peak_ok <= 1'b0;
        r        <= qa;
        cur_flux <= v;
      end
      ST_RISE_CMP: begin
        // step back while the flux still climbs and stays above the limit
        if (rd_data < cur_flux && {rd_data, 16'h0000} > limit) begin
          r        <= r - AW'(1);
          cur_flux <= rd_data;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- bench/flux_peak_picker_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_peak_picker_unit_tb
// Self-checking bench for the flux peak picker. A scoreboard class keeps its
// own copy of the flux store, the running maximum and the three share
// registers, predicts every result word from the accepted input words, and
// compares the words that leave the block field by field. Stimulus is a short
// directed part followed by random load runs and queries under changing
// register settings, one full-store fill, bursty input and a stalling output.
// ----------------------------------------------------------------------------

import fpp_pkg::*;

class peak_picker_model;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned PEAK_SPAN   = 3;
  localparam int unsigned LOCAL_SPAN  = 10;

  logic [31:0] flux_mem [STORE_DEPTH];
  int unsigned held;
  logic [31:0] loudest;
  logic [15:0] share_loud;
  logic [15:0] share_local;
  logic [15:0] rise_sh;
  result_t     pending_words [$];

  int unsigned failures;
  int unsigned n_loads;
  int unsigned n_drops;
  int unsigned n_queries;
  int unsigned n_in_range;
  int unsigned n_peaks;
  int unsigned longest_rise;

  function new();
    foreach (flux_mem[i]) flux_mem[i] = '0;
    held         = 0;
    loudest      = '0;
    share_loud   = SHARE_LOUDEST_RST;
    share_local  = SHARE_LOCAL_RST;
    rise_sh      = RISE_SHARE_RST;
    failures     = 0;
    n_loads      = 0;
    n_drops      = 0;
    n_queries    = 0;
    n_in_range   = 0;
    n_peaks      = 0;
    longest_rise = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      CFG_SHARE_LOUDEST: share_loud  = data;
      CFG_SHARE_LOCAL:   share_local = data;
      CFG_RISE_SHARE:    rise_sh     = data;
      default: ;
    endcase
  endfunction

  // Peak tests: loud enough, tallest nearby, above the local mean plus margin.
  function bit peak_at(int unsigned f);
    logic [63:0] v;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] lhs;
    logic [63:0] rhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned k;
    v = 64'(flux_mem[f]);
    if (loudest == 0) return 1'b0;
    if ((v << 16) < 64'(share_loud) * 64'(loudest)) return 1'b0;
    lo = (f > PEAK_SPAN) ? f - PEAK_SPAN : 0;
    hi = f + PEAK_SPAN + 1;
    if (hi > held) hi = held;
    for (k = lo; k < hi; k++)
      if (64'(flux_mem[k]) > v) return 1'b0;
    lo = (f > LOCAL_SPAN) ? f - LOCAL_SPAN : 0;
    hi = f + LOCAL_SPAN + 1;
    if (hi > held) hi = held;
    sum = '0;
    for (k = lo; k < hi; k++) sum += 64'(flux_mem[k]);
    n   = 64'(hi - lo);
    lhs = (v * n) << 16;
    rhs = (sum << 16) + 64'(share_local) * 64'(loudest) * n;
    return lhs > rhs;
  endfunction

  // Walk back while the flux keeps falling and stays above the rise share.
  function int unsigned rise_from(int unsigned f);
    logic [63:0] limit;
    int unsigned r;
    limit = 64'(rise_sh) * 64'(flux_mem[f]);
    r = f;
    while (r > 0 && flux_mem[r-1] < flux_mem[r] && (64'(flux_mem[r-1]) << 16) > limit)
      r--;
    return r;
  endfunction

  function void take_item(item_t w);
    result_t e;
    e = '0;
    if (w.operation == OP_LOAD) begin
      n_loads++;
      if (w.first_frame) begin
        held    = 0;
        loudest = '0;
      end
      if (held >= STORE_DEPTH) begin
        e.store_full = 1'b1;
        n_drops++;
      end else begin
        flux_mem[held] = w.flux_value;
        held++;
        if (w.flux_value > loudest) loudest = w.flux_value;
      end
    end else begin
      n_queries++;
      if (w.query_frame < held) begin
        e.in_range   = 1'b1;
        e.is_peak    = peak_at(w.query_frame);
        e.rise_frame = 12'(rise_from(w.query_frame));
        n_in_range++;
        if (e.is_peak) n_peaks++;
        if (w.query_frame - e.rise_frame > longest_rise)
          longest_rise = w.query_frame - e.rise_frame;
      end
    end
    e.frames_held = 13'(held);
    pending_words = {pending_words, e};
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%t  mismatch: %s", $time, msg);
  endfunction

  function void check_word(result_t got);
    result_t e;
    if (pending_words.size() == 0) begin
      note_failure($sformatf("result word with none expected: %p", got));
      return;
    end
    e = pending_words.pop_front();
    if (got.is_peak !== e.is_peak || got.rise_frame !== e.rise_frame ||
        got.in_range !== e.in_range || got.frames_held !== e.frames_held ||
        got.store_full !== e.store_full)
      note_failure($sformatf(
        {"exp peak=%0b rise=%0d inr=%0b held=%0d full=%0b / ",
         "got peak=%0b rise=%0d inr=%0b held=%0d full=%0b"},
        e.is_peak, e.rise_frame, e.in_range, e.frames_held, e.store_full,
        got.is_peak, got.rise_frame, got.in_range, got.frames_held, got.store_full));
  endfunction
endclass

module flux_peak_picker_unit_tb;
  import fpp_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1000;
  localparam int unsigned STORE_DEPTH  = 4096;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_write    = 1'b0;
  logic [1:0]  cfg_index    = CFG_SHARE_LOUDEST;
  logic [15:0] cfg_data     = '0;

  // Ask the output side for one long hold-off.
  logic        hold_req     = 1'b0;

  peak_picker_model model = new();

  // Sender and stimulus bookkeeping
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned gen_held   = 0;
  int unsigned settings   = 0;
  logic [31:0] last_flux  = '0;

  flux_peak_picker_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: everything is sampled at the edge, before this edge's updates land.
  // Check the outgoing word first so a same-edge input never shadows it.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) model.check_word(result);
      if (item_valid && item_ready) model.take_item(item);
      if (cfg_write) model.set_reg(cfg_index, cfg_data);
    end
  end

  // Output side: switch between stall patterns, plus one long hold-off on request.
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  int unsigned rx_tick    = 0;
  bit          hold_seen  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      rx_tick    = 0;
      hold_seen  = 1'b0;
    end else begin
      rx_tick++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        // hold the output off, count down the stretch
        hold_left--;
        result_ready <= 1'b0;
      end else if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 400;
        result_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       result_ready <= 1'b1;
          1:       result_ready <= ($urandom_range(0, 3) != 0);
          2:       result_ready <= ((rx_tick % 8) > 2);
          default: result_ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Offer one word and hold it until accepted. Bursts of random length with
  // random gaps between them.
  task automatic send_word(input item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic do_load(input bit first, input logic [31:0] v);
    item_t w;
    w.operation   = OP_LOAD;
    w.first_frame = first;
    w.flux_value  = v;
    w.query_frame = 12'($urandom);   // ignored on a load
    if (first) gen_held = 1;
    else if (gen_held < STORE_DEPTH) gen_held++;
    send_word(w);
  endtask

  task automatic do_query(input logic [11:0] f);
    item_t w;
    w.operation   = OP_QUERY;
    w.first_frame = 1'($urandom);    // ignored on a query
    w.flux_value  = $urandom;
    w.query_frame = f;
    send_word(w);
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (model.pending_words.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] loud, input logic [15:0] local_m,
                            input logic [15:0] rise);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SHARE_LOUDEST;
    cfg_data  <= loud;
    @(posedge clk);
    cfg_index <= CFG_SHARE_LOCAL;
    cfg_data  <= local_m;
    @(posedge clk);
    cfg_index <= CFG_RISE_SHARE;
    cfg_data  <= rise;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  function automatic logic [15:0] pick_share(input logic [15:0] dflt);
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return dflt;
      3, 4:    return 16'($urandom_range(0, 20000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly frames that are held, some just past the end, some anywhere.
  function automatic logic [11:0] pick_frame();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (gen_held == 0 || sel == 0) return 12'($urandom);
    if (sel == 1) return 12'(gen_held);
    if (sel == 2) return 12'(gen_held - 1);
    return 12'($urandom_range(0, gen_held - 1));
  endfunction

  // Flux shapes: low floor, ramps up and down, plateaus, ties, spikes, extremes.
  task automatic next_flux(output logic [31:0] v);
    case ($urandom_range(0, 11))
      0, 1, 2: v = $urandom_range(0, 255);
      3, 4:    v = last_flux + $urandom_range(1, 4096);
      5:       v = last_flux - $urandom_range(1, 4096);
      6:       v = $urandom_range(0, 7);
      7:       v = $urandom;
      8:       v = $urandom | 32'h8000_0000;
      9:       v = '0;
      10:      v = 32'hFFFF_FFFF;
      default: v = last_flux;
    endcase
    last_flux = v;
  endtask

  // One run of loads, a few queries mixed in, then a block of queries.
  task automatic send_run(input int unsigned len, input bit fresh);
    int unsigned k;
    int unsigned nq;
    logic [31:0] v;
    if (gen_held + len > 3000) fresh = 1'b1;
    for (k = 0; k < len; k++) begin
      next_flux(v);
      do_load(fresh && k == 0, v);
      if ($urandom_range(0, 9) == 0) do_query(pick_frame());
    end
    nq = $urandom_range(3, 12);
    for (k = 0; k < nq; k++) do_query(pick_frame());
  endtask

  initial begin
    int unsigned start;
    int unsigned phase;
    int unsigned runs;
    int unsigned k;
    logic [31:0] v;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store, loads without a first mark, a silent run.
    do_query(12'd0);
    do_load(1'b0, 32'd0);
    do_load(1'b0, 32'd0);
    do_query(12'd0);
    do_query(12'd1);
    // Small run with a tie at full scale and a rise in front of it.
    do_load(1'b1, 32'd1);
    do_load(1'b0, 32'h10);
    do_load(1'b0, 32'h100);
    do_load(1'b0, 32'hFFFF_FFFF);
    do_load(1'b0, 32'h100);
    do_load(1'b0, 32'hFFFF_FFFF);
    do_load(1'b0, 32'd0);
    do_query(12'd3);
    do_query(12'd5);
    do_query(12'd2);
    do_query(12'd0);
    do_query(12'd7);
    do_query(12'hFFF);
    // Single held frame under default, zero and full-scale shares.
    do_load(1'b1, 32'h8000_0000);
    do_query(12'd0);
    drain();
    write_regs(16'h0000, 16'h0000, 16'h0000);
    do_query(12'd0);
    drain();
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    do_query(12'd0);
    gen_held = 1;

    // Random phases: each starts idle with a fresh register setting.
    start = words_sent;
    phase = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      drain();
      write_regs(pick_share(SHARE_LOUDEST_RST), pick_share(SHARE_LOCAL_RST),
                 pick_share(RISE_SHARE_RST));
      phase++;
      // Hold the output off while the input keeps coming, to back the block up.
      if (phase == 3) hold_req <= 1'b1;
      if (phase == 8) begin
        // Fill the store to the top, with a long strict ramp near the end.
        for (k = 0; k < STORE_DEPTH; k++) begin
          if (k >= 3800) v = 32'h0010_0000 + k * 4096;
          else next_flux(v);
          do_load(k == 0, v);
        end
        // Drop a few loads on the full store.
        for (k = 0; k < 3; k++) begin
          next_flux(v);
          do_load(1'b0, v);
        end
        do_query(12'd4095);
        do_query(12'd4094);
        do_query(12'd3800);
        do_query(12'd0);
        for (k = 0; k < 8; k++) do_query(12'($urandom));
        send_run($urandom_range(1, 20), 1'b1);
      end else begin
        runs = $urandom_range(1, 3);
        for (k = 0; k < runs; k++)
          send_run(($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 40),
                   $urandom_range(0, 7) != 0);
      end
    end

    // Drain, then give the block time to show any stray word.
    drain();
    repeat (64) @(posedge clk);
    if (model.pending_words.size() != 0)
      model.note_failure($sformatf("%0d result words never came", model.pending_words.size()));

    $display("covered %0d loads (%0d dropped on a full store), %0d queries (%0d in range)",
             model.n_loads, model.n_drops, model.n_queries, model.n_in_range);
    $display("%0d peaks, longest rise %0d frames, %0d register settings, %0d mismatches",
             model.n_peaks, model.longest_rise, settings, model.failures);
    if (model.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fpp_pkg.sv
rtl/core/fpp_ram.sv
rtl/core/fpp_mul.sv
rtl/core/flux_peak_picker_unit.sv
bench/flux_peak_picker_unit_tb.sv
